// File: rtl/brf_pkg.sv
package brf_pkg;

    localparam int BRF_DEPTH_DEF = 1024;

    localparam int RING_W   = 11;
    localparam int FUNC_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int AMT_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam logic [RING_W-1:0] RING_SIZE_RESET = 11'd1024;

    // Operation codes carried by func.
    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_READ   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ADV_WR = 3'd3;
    localparam logic [FUNC_W-1:0] FN_ADV_RD = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd2;

    typedef struct packed {
        logic                cap_item;
        logic                exec;
        logic [STATUS_W-1:0] status;
        logic                take_data;
        logic                ram_we;
        logic                upd_wr;
        logic                upd_rd;
        logic                load_out;
    } brf_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              full;
        logic              empty;
        logic              peek_bad;
        logic              advw_bad;
        logic              advr_bad;
        logic              out_free;
    } brf_stat_t;

endpackage

// File: rtl/byte_ring_fifo.sv
// Byte ring FIFO that always keeps one slot empty, over a store of DEPTH bytes of
// which ring_size (clamped to 2..DEPTH) are in use. Each request writes, reads or peeks
// one byte, or advances the write or read point, and returns one result with the byte,
// a status and the free, contiguous-free, available, contiguous-available counts and
// both indexes after the request. A refused request changes nothing. A request is
// captured, executed with the byte store access, and its result loaded, as the store's
// read is registered; the load waits for a free output register, and no new request
// is taken before it. A result may wait in the output register while the next request
// is accepted. Writing ring_size empties the ring; do it only while idle.
module byte_ring_fifo
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [FUNC_W-1:0]   func,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [AMT_W-1:0]    amount,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   read_data,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  free_space,
    output logic [COUNT_W-1:0]  contiguous_space,
    output logic [COUNT_W-1:0]  available,
    output logic [COUNT_W-1:0]  contiguous_available,
    output logic [COUNT_W-1:0]  write_pos,
    output logic [COUNT_W-1:0]  read_pos,
    input  logic                cfg_wr_en,
    input  logic [RING_W-1:0]   cfg_wr_data
);

    brf_cmd_t  cmd;
    brf_stat_t stat;

    brf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    brf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .func                 (func),
        .data_byte            (data_byte),
        .amount               (amount),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_wr_data          (cfg_wr_data),
        .cmd                  (cmd),
        .stat                 (stat),
        .out_ready            (out_ready),
        .out_valid            (out_valid),
        .read_data            (read_data),
        .status               (status),
        .free_space           (free_space),
        .contiguous_space     (contiguous_space),
        .available            (available),
        .contiguous_available (contiguous_available),
        .write_pos            (write_pos),
        .read_pos             (read_pos)
    );

endmodule

// File: rtl/brf_ram.sv
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

// File: rtl/brf_ctrl.sv
module brf_ctrl
    import brf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  brf_stat_t stat,
    output brf_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        cmd           = '0;
        cmd.status    = ST_OK;
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.cap_item  = 1'b1;
                    state_next    = S_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = S_DONE;
                case (stat.func)
                    FN_WRITE:
                    begin
                        if (stat.full)
                        begin
                            cmd.status = ST_OVER;
                        end
                        else
                        begin
                            cmd.ram_we = 1'b1;
                            cmd.upd_wr = 1'b1;
                        end
                    end
                    FN_READ:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status = ST_UNDER;
                        end
                        else
                        begin
                            cmd.take_data = 1'b1;
                            cmd.upd_rd    = 1'b1;
                        end
                    end
                    FN_PEEK:
                    begin
                        if (stat.peek_bad)
                        begin
                            cmd.status = ST_UNDER;
                        end
                        else
                        begin
                            cmd.take_data = 1'b1;
                        end
                    end
                    FN_ADV_WR:
                    begin
                        if (stat.advw_bad)
                        begin
                            cmd.status = ST_OVER;
                        end
                        else
                        begin
                            cmd.upd_wr = 1'b1;
                        end
                    end
                    FN_ADV_RD:
                    begin
                        if (stat.advr_bad)
                        begin
                            cmd.status = ST_UNDER;
                        end
                        else
                        begin
                            cmd.upd_rd = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.status = ST_OK;
                    end
                endcase
            end
            S_DONE:
            begin
                // The result waits here until the output register is free.
                if (stat.out_free)
                begin
                    cmd.load_out  = 1'b1;
                    state_next    = S_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = S_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: rtl/brf_datapath.sv
module brf_datapath
    import brf_pkg::*;
#(
    parameter int DEPTH = BRF_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [FUNC_W-1:0]   func,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [AMT_W-1:0]    amount,
    input  logic                cfg_wr_en,
    input  logic [RING_W-1:0]   cfg_wr_data,
    input  brf_cmd_t            cmd,
    output brf_stat_t           stat,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [BYTE_W-1:0]   read_data,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  free_space,
    output logic [COUNT_W-1:0]  contiguous_space,
    output logic [COUNT_W-1:0]  available,
    output logic [COUNT_W-1:0]  contiguous_available,
    output logic [COUNT_W-1:0]  write_pos,
    output logic [COUNT_W-1:0]  read_pos
);

    localparam int AW = $clog2(DEPTH);
    localparam int SW = $clog2(DEPTH + 1);
    localparam int CW = (SW > RING_W) ? SW : RING_W;
    localparam int PW = ((SW > AMT_W) ? SW : AMT_W) + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] MIN_SIZE = CW'(2);

    logic [RING_W-1:0]   ring_size_reg;
    logic [AW-1:0]       wr_idx_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic [FUNC_W-1:0]   func_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [AMT_W-1:0]    amount_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                rdsel_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   read_data_reg;
    logic [STATUS_W-1:0] status_out_reg;
    logic [COUNT_W-1:0]  free_reg;
    logic [COUNT_W-1:0]  cspace_reg;
    logic [COUNT_W-1:0]  avail_reg;
    logic [COUNT_W-1:0]  cavail_reg;
    logic [COUNT_W-1:0]  wpos_reg;
    logic [COUNT_W-1:0]  rpos_reg;

    logic [CW-1:0]     rs_ext;
    logic [CW-1:0]     size_c;
    logic [SW-1:0]     size_s;
    logic [SW-1:0]     wr_s;
    logic [SW-1:0]     rd_s;
    logic [SW-1:0]     av;
    logic [SW-1:0]     fr;
    logic [SW-1:0]     cspace;
    logic [SW-1:0]     cavail;
    logic [PW-1:0]     amt_ext;
    logic              uses_wr;
    logic              single_step;
    logic [PW-1:0]     step_n;
    logic [PW-1:0]     sum;
    logic [PW-1:0]     wrapped;
    logic [AW-1:0]     bump_idx;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // The size in use is the register clamped to the range 2 to DEPTH.
    always_comb
    begin
        rs_ext = CW'(ring_size_reg);
        if (rs_ext < MIN_SIZE)
        begin
            size_c = MIN_SIZE;
        end
        else if (rs_ext > DEPTH_C)
        begin
            size_c = DEPTH_C;
        end
        else
        begin
            size_c = rs_ext;
        end
        size_s = size_c[SW-1:0];
    end

    assign wr_s = SW'(wr_idx_reg);
    assign rd_s = SW'(rd_idx_reg);

    always_comb
    begin
        if (rd_s <= wr_s)
        begin
            av     = wr_s - rd_s;
            cavail = wr_s - rd_s;
        end
        else
        begin
            av     = size_s - rd_s + wr_s;
            cavail = size_s - rd_s;
        end
        fr = size_s - SW'(1) - av;
        if (wr_s < rd_s)
        begin
            cspace = rd_s - wr_s - SW'(1);
        end
        else if (rd_s == '0)
        begin
            cspace = size_s - wr_s - SW'(1);
        end
        else
        begin
            cspace = size_s - wr_s;
        end
    end

    // One shared adder moves an index forward and wraps it once.
    assign uses_wr     = (func_reg == FN_WRITE) || (func_reg == FN_ADV_WR);
    assign single_step = (func_reg == FN_WRITE) || (func_reg == FN_READ);
    assign amt_ext     = PW'(amount_reg);
    assign step_n      = single_step ? PW'(1) : amt_ext;
    assign sum         = (uses_wr ? PW'(wr_idx_reg) : PW'(rd_idx_reg)) + step_n;
    assign wrapped     = (sum >= PW'(size_s)) ? (sum - PW'(size_s)) : sum;
    assign bump_idx    = wrapped[AW-1:0];

    assign raddr = (func_reg == FN_PEEK) ? bump_idx : rd_idx_reg;

    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.ram_we),
        .waddr (wr_idx_reg),
        .wdata (byte_reg),
        .re    (cmd.exec),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        stat.func     = func_reg;
        stat.full     = (fr == '0);
        stat.empty    = (av == '0);
        stat.peek_bad = (amt_ext >= PW'(av));
        stat.advw_bad = (amt_ext > PW'(fr));
        stat.advr_bad = (amt_ext > PW'(av));
        stat.out_free = !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= RING_SIZE_RESET;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd_wr)
            begin
                wr_idx_reg <= bump_idx;
            end
            if (cmd.upd_rd)
            begin
                rd_idx_reg <= bump_idx;
            end
            // Size change empties ring; user must do it only while idle.
            if (cfg_wr_en)
            begin
                ring_size_reg <= cfg_wr_data;
                wr_idx_reg    <= '0;
                rd_idx_reg    <= '0;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_item)
        begin
            func_reg   <= func;
            byte_reg   <= data_byte;
            amount_reg <= amount;
        end
        if (cmd.exec)
        begin
            status_reg <= cmd.status;
            rdsel_reg  <= cmd.take_data;
        end
        if (cmd.load_out)
        begin
            read_data_reg  <= rdsel_reg ? ram_rdata : '0;
            status_out_reg <= status_reg;
            free_reg       <= COUNT_W'(fr);
            cspace_reg     <= COUNT_W'(cspace);
            avail_reg      <= COUNT_W'(av);
            cavail_reg     <= COUNT_W'(cavail);
            wpos_reg       <= COUNT_W'(wr_idx_reg);
            rpos_reg       <= COUNT_W'(rd_idx_reg);
        end
    end

    assign out_valid            = out_valid_reg;
    assign read_data            = read_data_reg;
    assign status               = status_out_reg;
    assign free_space           = free_reg;
    assign contiguous_space     = cspace_reg;
    assign available            = avail_reg;
    assign contiguous_available = cavail_reg;
    assign write_pos            = wpos_reg;
    assign read_pos             = rpos_reg;

endmodule
